>>> hw/rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  // field widths fixed by the interface
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  // capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // data returned by a get miss
  localparam logic [VALUE_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // take an input word and run the key and lru compares
    logic commit;   // apply the update and load the result register
  } lkvc_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/lru_key_value_cache.sv
// sequencing: an input word is captured with its compare results, then the rank
//   and store update commits and loads the result register; the next input word
//   is taken only after that update, which the next word's compare depends on;
//   a stalled result word holds off the next input word
// reset: valid bits, recency ranks and occupancy clear at once, capacity
//   returns to 16; key and value stores are not cleared and need no pass
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]    key_i,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0]  value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      hit_o,
  output logic signed [lkvc_pkg::VALUE_W-1:0]       data_o,
  output logic                                      evicted_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]           cfg_wdata_i
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;

  // handshake and sequencing
  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // entry storage, compare and update
  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .hit_o       (hit_o),
    .data_o      (data_o),
    .evicted_o   (evicted_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lkvc_pkg::lkvc_cmd_t    cmd_o
);
  import lkvc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   out_valid_q;

  // command decode
  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit  = (state_q == ST_UPDATE) && !(out_valid_q && out_stall_i);
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_UPDATE;
            stall_q <= 1'b1;
          end
        end
        ST_UPDATE: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lkvc_pkg::lkvc_cmd_t                  cmd_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]           cfg_wdata_i,
  input  wire logic                                 op_i,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]    key_i,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0]  value_i,
  output logic                                      hit_o,
  output logic signed [lkvc_pkg::VALUE_W-1:0]       data_o,
  output logic                                      evicted_o
);
  import lkvc_pkg::*;

  localparam int N  = MAX_ENTRIES;
  localparam int RW = (N > 1) ? $clog2(N) : 1;
  localparam int OW = $clog2(N + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [CW-1:0] MaxCw = CW'(N);

  // entry state
  logic [KEY_W-1:0]   key_mem [N];
  logic [VALUE_W-1:0] val_mem [N];
  logic [N-1:0]       valid_q;
  logic [RW-1:0]      rank_q [N];
  logic [OW-1:0]      occ_q;
  logic [CAP_W-1:0]   cap_q;

  // item held between compare and update
  logic               p_op_q;
  logic [KEY_W-1:0]   p_key_q;
  logic [VALUE_W-1:0] p_val_q;
  logic [N-1:0]       p_match_q;
  logic [N-1:0]       p_lru_q;
  logic [RW-1:0]      p_free_q;
  logic               p_evict_q;

  // result register
  logic               hit_q;
  logic [VALUE_W-1:0] data_q;
  logic               evicted_q;

  // compare stage signals
  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic [RW-1:0]      occ_m1;
  logic [N-1:0]       match_vec;
  logic [N-1:0]       lru_vec;
  logic [RW-1:0]      free_idx;
  logic               evict_need;

  // update stage signals
  logic               hit;
  logic               is_put;
  logic               insert;
  logic               do_promote;
  logic [N-1:0]       sel_vec;
  logic [RW-1:0]      slot;
  logic [RW-1:0]      slot_rank;
  logic [N-1:0]       age_vec;

  // effective capacity, clamped to 1..N
  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > MaxCw) begin
      eff_cap = MaxCw;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // least recent entry always holds rank occupancy-1
  assign occ_m1     = RW'(occ_q - OW'(1));
  assign evict_need = (CW'(occ_q) >= eff_cap);

  // parallel key and rank compare
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i] = valid_q[i] && (key_mem[i] == key_i);
      lru_vec[i]   = valid_q[i] && (rank_q[i] == occ_m1);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = RW'(i);
      end
    end
  end

  // capture input word and compare results
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      p_op_q    <= op_i;
      p_key_q   <= key_i;
      p_val_q   <= value_i;
      p_match_q <= match_vec;
      p_lru_q   <= lru_vec;
      p_free_q  <= free_idx;
      p_evict_q <= evict_need;
    end
  end

  // slot selection for the update
  always_comb begin
    hit        = |p_match_q;
    is_put     = (p_op_q == OP_PUT);
    insert     = is_put && !hit && !p_evict_q;
    do_promote = hit || is_put;
    sel_vec    = hit ? p_match_q : p_lru_q;
    slot       = '0;
    if (insert) begin
      slot = p_free_q;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (sel_vec[i]) begin
          slot = slot | RW'(i);
        end
      end
    end
  end

  assign slot_rank = rank_q[slot];

  // entries that age by one step
  always_comb begin
    for (int i = 0; i < N; i++) begin
      age_vec[i] = valid_q[i] && (RW'(i) != slot) && (insert || (rank_q[i] < slot_rank));
    end
  end

  // control state: capacity, valid bits, ranks, occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        if (do_promote) begin
          for (int i = 0; i < N; i++) begin
            if (RW'(i) == slot) begin
              rank_q[i] <= '0;
            end else if (age_vec[i]) begin
              rank_q[i] <= rank_q[i] + RW'(1);
            end
          end
        end
        if (insert) begin
          valid_q[slot] <= 1'b1;
          occ_q         <= occ_q + OW'(1);
        end
      end
    end
  end

  // key array, compared in parallel
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_put && !hit) begin
      key_mem[slot] <= p_key_q;
    end
  end

  // value memory with registered read into the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (is_put) begin
        val_mem[slot] <= p_val_q;
      end
      hit_q     <= hit;
      evicted_q <= is_put && !hit && p_evict_q;
      if (is_put) begin
        data_q <= '0;
      end else if (hit) begin
        data_q <= val_mem[slot];
      end else begin
        data_q <= MISS_DATA;
      end
    end
  end

  assign hit_o     = hit_q;
  assign data_o    = data_q;
  assign evicted_o = evicted_q;

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic                                 hit_o,
  input wire logic signed [lkvc_pkg::VALUE_W-1:0]  data_o,
  input wire logic                                 evicted_o
);
  import lkvc_pkg::*;

  // one word at a time: a taken word stalls the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // an eviction only happens on a put miss
  a_evict_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> (!hit_o && (data_o == '0)))
    else $error("eviction reported with hit or nonzero data");

  // a miss returns either the get miss marker or the put zero
  a_miss_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o && (data_o != '0)) |-> (data_o == MISS_DATA))
    else $error("miss result carries unexpected data");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(data_o) && $stable(hit_o) && $stable(evicted_o)))
    else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .data_o      (data_o),
  .evicted_o   (evicted_o)
);

`default_nettype wire
